// ===== sv/ffba_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
// No dependencies.
package ffba_pkg;
  localparam int unsigned Entries  = 16;
  localparam int unsigned IdxBits  = $clog2(Entries);
  localparam int unsigned AddrBits = 16;
  localparam int unsigned LenBits  = 16;
  localparam logic [LenBits-1:0] PoolReset = 16'd1024;

  // stream widths: fields packed from bit 0, padded to whole bytes
  localparam int unsigned InBits       = LenBits + AddrBits;
  localparam int unsigned InTdataBits  = (InBits + 7) / 8 * 8;
  localparam int unsigned OutBits      = 2 + AddrBits + LenBits;
  localparam int unsigned OutTdataBits = (OutBits + 7) / 8 * 8;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoFit   = 2'd1;
  localparam logic [1:0] StUnknown = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  typedef struct packed {
    logic start;   // load request, clear scan
    logic step;    // examine entry at scan index
    logic commit;  // update tables and load result
  } ffba_cmd_t;

  typedef struct packed {
    logic last;    // scan index at final entry
  } ffba_sts_t;
endpackage

// ===== sv/ffba_datapath.sv =====
// Tables, scan registers and result register of the allocator.
// Depends on ffba_pkg.
module ffba_datapath import ffba_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [LenBits-1:0]  cfg_wdata_i,
  input  logic                op_i,
  input  logic [LenBits-1:0]  size_i,
  input  logic [AddrBits-1:0] addr_i,
  input  ffba_cmd_t           cmd_i,
  output ffba_sts_t           sts_o,
  output logic [1:0]          status_o,
  output logic [AddrBits-1:0] baddr_o,
  output logic [LenBits-1:0]  blen_o
);
  logic [AddrBits-1:0] fstart_q [Entries];
  logic [LenBits-1:0]  flen_q   [Entries];
  logic [Entries-1:0]  fuse_q;
  logic [AddrBits-1:0] astart_q [Entries];
  logic [LenBits-1:0]  alen_q   [Entries];
  logic [Entries-1:0]  ause_q;

  logic                op_q;
  logic [LenBits-1:0]  size_q;
  logic [AddrBits-1:0] addr_q;
  logic [IdxBits-1:0]  idx_q;
  logic                hit_q, fslot_ok_q, aslot_ok_q;
  logic [IdxBits-1:0]  hit_idx_q, fslot_q, aslot_q;

  logic hit_d;
  logic better;
  assign sts_o.last = (idx_q == IdxBits'(Entries - 1));
  assign better = fuse_q[idx_q] && (flen_q[idx_q] >= size_q) &&
                  (!hit_q || fstart_q[idx_q] < fstart_q[hit_idx_q]);
  assign hit_d = (op_q == OpAlloc) ? better
               : (ause_q[idx_q] && astart_q[idx_q] == addr_q && !hit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fuse_q <= Entries'(1);
      ause_q <= '0;
      for (int i = 0; i < Entries; i++) begin
        fstart_q[i] <= '0;
        flen_q[i]   <= (i == 0) ? PoolReset : '0;
        astart_q[i] <= '0;
        alen_q[i]   <= '0;
      end
      idx_q <= '0;
      hit_q <= 1'b0;
      hit_idx_q <= '0;
      fslot_ok_q <= 1'b0;
      fslot_q <= '0;
      aslot_ok_q <= 1'b0;
      aslot_q <= '0;
      status_o <= StOk;
      baddr_o <= '0;
      blen_o <= '0;
    end else if (cfg_we_i) begin
      ause_q <= '0;
      fuse_q <= Entries'(cfg_wdata_i != '0);
      fstart_q[0] <= '0;
      flen_q[0] <= cfg_wdata_i;
    end else if (cmd_i.start) begin
      idx_q <= '0;
      hit_q <= 1'b0;
      fslot_ok_q <= 1'b0;
      aslot_ok_q <= 1'b0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + 1'b1;
      if (hit_d) begin
        hit_q <= 1'b1;
        hit_idx_q <= idx_q;
      end
      // track lowest empty slot in each table
      if (!fuse_q[idx_q] && !fslot_ok_q) begin
        fslot_ok_q <= 1'b1;
        fslot_q <= idx_q;
      end
      if (!ause_q[idx_q] && !aslot_ok_q) begin
        aslot_ok_q <= 1'b1;
        aslot_q <= idx_q;
      end
    end else if (cmd_i.commit) begin
      if (op_q == OpAlloc) begin
        if (size_q == '0 || !hit_q) begin
          status_o <= StNoFit;
          baddr_o  <= '0;
          blen_o   <= '0;
        end else if (!aslot_ok_q) begin
          status_o <= StFull;
          baddr_o  <= '0;
          blen_o   <= '0;
        end else begin
          astart_q[aslot_q] <= fstart_q[hit_idx_q];
          alen_q[aslot_q]   <= size_q;
          ause_q[aslot_q]   <= 1'b1;
          status_o <= StOk;
          baddr_o  <= fstart_q[hit_idx_q];
          blen_o   <= size_q;
          if (flen_q[hit_idx_q] == size_q) begin
            fuse_q[hit_idx_q]   <= 1'b0;
            fstart_q[hit_idx_q] <= '0;
            flen_q[hit_idx_q]   <= '0;
          end else begin
            fstart_q[hit_idx_q] <= fstart_q[hit_idx_q] + AddrBits'(size_q);
            flen_q[hit_idx_q]   <= flen_q[hit_idx_q] - size_q;
          end
        end
      end else begin
        if (!hit_q) begin
          status_o <= StUnknown;
          baddr_o  <= '0;
          blen_o   <= '0;
        end else if (!fslot_ok_q) begin
          status_o <= StFull;
          baddr_o  <= '0;
          blen_o   <= '0;
        end else begin
          fstart_q[fslot_q] <= astart_q[hit_idx_q];
          flen_q[fslot_q]   <= alen_q[hit_idx_q];
          fuse_q[fslot_q]   <= 1'b1;
          ause_q[hit_idx_q] <= 1'b0;
          status_o <= StOk;
          baddr_o  <= astart_q[hit_idx_q];
          blen_o   <= alen_q[hit_idx_q];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q   <= op_i;
      size_q <= size_i;
      addr_q <= addr_i;
    end
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.start, cmd_i.step, cmd_i.commit})) else $error("cmd overlap");
  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.commit) && status_o == StOk && !$past(cfg_we_i) |-> blen_o != '0)
    else $error("ok with zero length");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.commit) && status_o != StOk && !$past(cfg_we_i) |-> baddr_o == '0)
    else $error("error with address");
endmodule

// ===== sv/ffba_ctrl.sv =====
// Controller FSM: accept, scan, commit, hold result.
// Depends on ffba_pkg.
module ffba_ctrl import ffba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ffba_sts_t sts_i,
  output ffba_cmd_t cmd_o
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_COMMIT = 4'b0100, S_OUT = 4'b1000
  } state_e;
  state_e state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cmd_o.start  = in_ready_o && in_valid_i;
  assign cmd_o.step   = (state_q == S_SCAN);
  assign cmd_o.commit = (state_q == S_COMMIT);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_SCAN;
      S_SCAN:   if (sts_i.last) state_d = S_COMMIT;
      S_COMMIT: state_d = S_OUT;
      S_OUT:    if (out_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o) else $error("no result after commit");
endmodule

// ===== sv/first_fit_block_allocator_top.sv =====
// First-fit allocator over 16-entry free and allocated tables.
// Each word is accepted, scanned over both tables (one entry a cycle) and
// committed; the result is then held until taken, and the next word is only
// accepted after that. Reset (async, active low) loads one free block
// (0, 1024); a pool_size write reloads the tables with one block (0, pool_size), none if zero.
module first_fit_block_allocator_top import ffba_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [LenBits-1:0]      cfg_wdata_i,   // pool_size
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic                    s_axis_tuser,  // op
  input  logic [InTdataBits-1:0]  s_axis_tdata,  // request_size[15:0], free_address[31:16]
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OutTdataBits-1:0] m_axis_tdata   // status[1:0], block_address[17:2], block_length[33:18]
);
  ffba_cmd_t cmd;
  ffba_sts_t sts;
  logic [1:0] status;
  logic [AddrBits-1:0] baddr;
  logic [LenBits-1:0] blen;

  ffba_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  ffba_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .op_i(s_axis_tuser), .size_i(s_axis_tdata[LenBits-1:0]),
    .addr_i(s_axis_tdata[LenBits +: AddrBits]),
    .cmd_i(cmd), .sts_o(sts), .status_o(status), .baddr_o(baddr), .blen_o(blen)
  );

  assign m_axis_tdata = OutTdataBits'({blen, baddr, status});
endmodule

// ===== verif/tb_first_fit_block_allocator_top.sv =====
// Self-checking testbench for the first-fit block allocator top level.
// Depends on ffba_pkg and first_fit_block_allocator_top; predicts each result
// from its own copy of the free and allocated tables.
module tb_first_fit_block_allocator_top import ffba_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] addr;
    logic [15:0] len;
  } grant_t;

  localparam int unsigned WatchdogLimit = 20000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [15:0]             cfg_wdata_i = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic                    s_axis_tuser = 1'b0;
  logic [InTdataBits-1:0]  s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutTdataBits-1:0] m_axis_tdata;

  first_fit_block_allocator_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [15:0] pool_units;
  logic [15:0] fr_start [Entries];
  logic [15:0] fr_len   [Entries];
  logic        fr_used  [Entries];
  logic [15:0] al_start [Entries];
  logic [15:0] al_len   [Entries];
  logic        al_used  [Entries];

  grant_t pending_grants[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int ok_allocs = 0, ok_frees = 0, full_hits = 0, unknown_hits = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  int idle_cycles = 0;

  function automatic void reload_tables(input logic [15:0] units);
    pool_units = units;
    for (int i = 0; i < Entries; i++) begin
      fr_start[i] = '0; fr_len[i] = '0; fr_used[i] = 1'b0;
      al_start[i] = '0; al_len[i] = '0; al_used[i] = 1'b0;
    end
    if (units != 0) begin
      fr_len[0] = units;
      fr_used[0] = 1'b1;
    end
  endfunction

  function automatic grant_t predict_grant(input logic op, input logic [15:0] size,
                                           input logic [15:0] faddr);
    grant_t g;
    int best, slot, found;
    g = '{StNoFit, 16'd0, 16'd0};
    best = -1; slot = -1; found = -1;
    if (op == OpAlloc) begin
      if (size == 0) return g;
      for (int i = 0; i < Entries; i++)
        if (fr_used[i] && fr_len[i] >= size &&
            (best < 0 || fr_start[i] < fr_start[best])) best = i;
      if (best < 0) return g;
      for (int i = Entries - 1; i >= 0; i--) if (!al_used[i]) slot = i;
      if (slot < 0) begin
        g.status = StFull;
        return g;
      end
      al_start[slot] = fr_start[best];
      al_len[slot] = size;
      al_used[slot] = 1'b1;
      g = '{StOk, fr_start[best], size};
      if (fr_len[best] == size) begin
        fr_used[best] = 1'b0; fr_start[best] = '0; fr_len[best] = '0;
      end else begin
        fr_start[best] = fr_start[best] + size;
        fr_len[best] = fr_len[best] - size;
      end
    end else begin
      for (int i = Entries - 1; i >= 0; i--)
        if (al_used[i] && al_start[i] == faddr) found = i;
      if (found < 0) begin
        g.status = StUnknown;
        return g;
      end
      for (int i = Entries - 1; i >= 0; i--) if (!fr_used[i]) slot = i;
      if (slot < 0) begin
        g.status = StFull;
        return g;
      end
      fr_start[slot] = al_start[found];
      fr_len[slot] = al_len[found];
      fr_used[slot] = 1'b1;
      al_used[found] = 1'b0;
      g = '{StOk, al_start[found], al_len[found]};
      al_start[found] = '0; al_len[found] = '0;
    end
    return g;
  endfunction

  // Send one word; predicted at acceptance so table order matches the block.
  task automatic send_request(input logic op, input logic [15:0] size,
                              input logic [15:0] faddr);
    grant_t g;
    // step off the edge that dropped the previous word
    @(posedge clk_i);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= InTdataBits'({faddr, size});
    do @(posedge clk_i); while (!s_axis_tready);
    g = predict_grant(op, size, faddr);
    pending_grants.push_back(g);
    words_sent++;
    if (g.status == StOk && op == OpAlloc) ok_allocs++;
    if (g.status == StOk && op == OpFree) ok_frees++;
    if (g.status == StFull) full_hits++;
    if (g.status == StUnknown) unknown_hits++;
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_pool(input logic [15:0] units);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= units;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reload_tables(units);
  endtask

  // Pick the start of a live allocation, or a random address.
  function automatic logic [15:0] pick_live_addr();
    int cand[$];
    for (int i = 0; i < Entries; i++) if (al_used[i]) cand.push_back(i);
    if (cand.size() == 0) return 16'($urandom());
    return al_start[cand[$urandom_range(cand.size() - 1)]];
  endfunction

  task automatic random_mix(input int count, input int max_size);
    logic [15:0] sz;
    for (int n = 0; n < count; n++) begin
      sz = 16'($urandom_range(max_size, 1));
      case ($urandom_range(19))
        0: send_request(OpAlloc, 16'($urandom()), 16'($urandom()));
        1: send_request(OpFree, 16'($urandom()), 16'($urandom()));
        2: send_request(OpAlloc, 16'd0, 16'($urandom()));
        3, 4, 5, 6, 7, 8: send_request(OpFree, 16'($urandom()), pick_live_addr());
        default: send_request(OpAlloc, sz, 16'($urandom()));
      endcase
    end
  endtask

  task automatic test_directed();
    send_request(OpAlloc, 16'd0, 16'hFFFF);       // zero size
    send_request(OpAlloc, 16'hFFFF, 16'd0);       // no fit
    send_request(OpFree, 16'd0, 16'd0);           // unknown address
    send_request(OpAlloc, 16'd100, 16'd0);
    send_request(OpAlloc, 16'd924, 16'd0);        // exact fit empties the pool
    send_request(OpAlloc, 16'd1, 16'd0);
    send_request(OpFree, 16'd0, 16'd100);
    send_request(OpFree, 16'd0, 16'd0);
    send_request(OpAlloc, 16'd50, 16'd0);         // lowest start wins
    write_pool(16'hFFFF);
    send_request(OpAlloc, 16'hFFFF, 16'hAAAA);
    send_request(OpFree, 16'h5555, 16'd0);
    write_pool(16'd0);                            // empty pool
    send_request(OpAlloc, 16'd1, 16'd0);
    write_pool(16'd64);
    // fill the allocated table, then overflow it
    for (int i = 0; i < Entries + 1; i++) send_request(OpAlloc, 16'd1, 16'd0);
  endtask

  task automatic test_free_table_full();
    // scatter frees so the free table fills up without coalescing
    write_pool(16'd40);
    for (int i = 0; i < Entries; i++) send_request(OpAlloc, 16'd2, 16'd0);
    for (int i = 0; i < Entries; i += 2) send_request(OpFree, 16'd0, 16'(2 * i));
    for (int i = 1; i < Entries; i += 2) send_request(OpFree, 16'd0, 16'(2 * i));
  endtask

  task automatic test_random_phases();
    write_pool(16'd1024);
    random_mix(290, 200);
    send_idle_pct = 84;
    random_mix(130, 64);
    send_idle_pct = 0; recv_stall_pct = 84;
    write_pool(16'd200);
    random_mix(130, 40);
    send_idle_pct = 29; recv_stall_pct = 29;
    write_pool(16'($urandom_range(65535, 300)));
    random_mix(150, 4000);
    send_idle_pct = 0; recv_stall_pct = 0;
    write_pool(16'd1);
    random_mix(20, 2);
  endtask

  task automatic test_backpressure();
    write_pool(16'd512);
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      random_mix(20, 50);
    join
    drain_results();                              // sender waits for all results
    random_mix(150, 100);
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    grant_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[1:0];
      got.addr   = m_axis_tdata[17:2];
      got.len    = m_axis_tdata[33:18];
      words_checked++;
      if (pending_grants.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, got);
        errors++;
      end else begin
        want = pending_grants.pop_front();
        if (got.status != want.status) begin
          $display("%0t status: expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.addr != want.addr) begin
          $display("%0t block_address: expected %h actual %h", $time, want.addr, got.addr);
          errors++;
        end
        if (got.len != want.len) begin
          $display("%0t block_length: expected %h actual %h", $time, want.len, got.len);
          errors++;
        end
      end
    end
    m_axis_tready <= rst_ni && !hold_off &&
                     !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d results outstanding", pending_grants.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    reload_tables(PoolReset);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_free_table_full();
    test_random_phases();
    test_backpressure();
    drain_results();
    $display("sent %0d requests, checked %0d results: %0d allocs, %0d frees ok",
             words_sent, words_checked, ok_allocs, ok_frees);
    $display("table full %0d, unknown address %0d", full_hits, unknown_hits);
    if (errors == 0 && pending_grants.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
sv/ffba_pkg.sv
sv/ffba_datapath.sv
sv/ffba_ctrl.sv
sv/first_fit_block_allocator_top.sv
verif/tb_first_fit_block_allocator_top.sv
